FILE: sv/usdd_pkg.sv
package usdd_pkg;

    localparam int unsigned UPC_W = 4;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [2:0] {
        UOP_WAIT  = 3'd0,
        UOP_QUO   = 3'd1,
        UOP_REM   = 3'd2,
        UOP_LDW   = 3'd3,
        UOP_LDD   = 3'd4,
        UOP_YEAR  = 3'd5,
        UOP_MONTH = 3'd6,
        UOP_PACK  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        DSEL_DAY  = 2'd0,
        DSEL_HOUR = 2'd1,
        DSEL_MIN  = 2'd2,
        DSEL_WEEK = 2'd3
    } t_dsel;

    typedef enum logic [1:0] {
        DST_DAYS   = 2'd0,
        DST_HOUR   = 2'd1,
        DST_MINSEC = 2'd2,
        DST_WDAY   = 2'd3
    } t_dst;

    typedef struct packed {
        t_op        op;
        t_dsel      dsel;
        t_dst       dst;
        t_upc       target;
    } t_uword;

    // program addresses
    localparam t_upc UA_WAIT   = 4'd0;
    localparam t_upc UA_DAY_Q  = 4'd1;
    localparam t_upc UA_DAY_R  = 4'd2;
    localparam t_upc UA_HOUR_Q = 4'd3;
    localparam t_upc UA_HOUR_R = 4'd4;
    localparam t_upc UA_MIN_Q  = 4'd5;
    localparam t_upc UA_MIN_R  = 4'd6;
    localparam t_upc UA_LDW    = 4'd7;
    localparam t_upc UA_WEEK_Q = 4'd8;
    localparam t_upc UA_WEEK_R = 4'd9;
    localparam t_upc UA_LDD    = 4'd10;
    localparam t_upc UA_YEAR   = 4'd11;
    localparam t_upc UA_MONTH  = 4'd12;
    localparam t_upc UA_PACK   = 4'd13;

    localparam logic [31:0] NO_TIME     = 32'hFFFF_FFFF;
    localparam logic [7:0]  BASE_YEAR   = 8'd70;
    localparam logic [7:0]  DOS_YEAR    = 8'd80;
    localparam logic [7:0]  YEAR_2000   = 8'd100;
    localparam logic [7:0]  YEAR_2100   = 8'd200;
    localparam logic [31:0] WDAY_OFFSET = 32'd4;
    localparam logic [3:0]  LAST_MONTH  = 4'd11;
    localparam logic [3:0]  FEBRUARY    = 4'd1;

    // year counted from 1900; within 1900..2155 only 2000 is a leap century
    function automatic logic is_leap(input logic [7:0] yr);
        return (yr[1:0] == 2'b00) && (yr != 8'd0) && (yr != YEAR_2100);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [16:0] divisor(input t_dsel sel);
        logic [16:0] d;
        case (sel)
            DSEL_DAY:  d = 17'd86400;
            DSEL_HOUR: d = 17'd3600;
            DSEL_MIN:  d = 17'd60;
            DSEL_WEEK: d = 17'd7;
            default:   d = 17'd7;
        endcase
        return d;
    endfunction

    // Quotient by reciprocal: floor((num >> p) * m / 2^s), exact over each
    // step's dividend range (86400 = 128*675, 3600 = 16*225, 60 = 4*15).
    function automatic logic [24:0] pre_scale(input t_dsel sel, input logic [31:0] num);
        logic [24:0] x;
        case (sel)
            DSEL_DAY:  x = num[31:7];
            DSEL_HOUR: x = num[28:4];
            DSEL_MIN:  x = num[26:2];
            DSEL_WEEK: x = num[24:0];
            default:   x = num[24:0];
        endcase
        return x;
    endfunction

    function automatic logic [25:0] recip(input t_dsel sel);
        logic [25:0] m;
        case (sel)
            DSEL_DAY:  m = 26'd50903317;   // ceil(2^35 / 675)
            DSEL_HOUR: m = 26'd9321;       // ceil(2^21 / 225)
            DSEL_MIN:  m = 26'd1093;       // ceil(2^14 / 15)
            DSEL_WEEK: m = 26'd74899;      // ceil(2^19 / 7)
            default:   m = 26'd74899;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] quo_pick(input t_dsel sel, input logic [50:0] p);
        logic [15:0] q;
        case (sel)
            DSEL_DAY:  q = p[50:35];
            DSEL_HOUR: q = p[36:21];
            DSEL_MIN:  q = p[29:14];
            DSEL_WEEK: q = p[34:19];
            default:   q = p[34:19];
        endcase
        return q;
    endfunction

    // control store
    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        case (a)
            UA_WAIT:   w = '{UOP_WAIT,  DSEL_DAY,  DST_DAYS,   UA_PACK};
            UA_DAY_Q:  w = '{UOP_QUO,   DSEL_DAY,  DST_DAYS,   UA_DAY_R};
            UA_DAY_R:  w = '{UOP_REM,   DSEL_DAY,  DST_DAYS,   UA_HOUR_Q};
            UA_HOUR_Q: w = '{UOP_QUO,   DSEL_HOUR, DST_HOUR,   UA_HOUR_R};
            UA_HOUR_R: w = '{UOP_REM,   DSEL_HOUR, DST_HOUR,   UA_MIN_Q};
            UA_MIN_Q:  w = '{UOP_QUO,   DSEL_MIN,  DST_MINSEC, UA_MIN_R};
            UA_MIN_R:  w = '{UOP_REM,   DSEL_MIN,  DST_MINSEC, UA_LDW};
            UA_LDW:    w = '{UOP_LDW,   DSEL_DAY,  DST_DAYS,   UA_WEEK_Q};
            UA_WEEK_Q: w = '{UOP_QUO,   DSEL_WEEK, DST_WDAY,   UA_WEEK_R};
            UA_WEEK_R: w = '{UOP_REM,   DSEL_WEEK, DST_WDAY,   UA_LDD};
            UA_LDD:    w = '{UOP_LDD,   DSEL_DAY,  DST_DAYS,   UA_YEAR};
            UA_YEAR:   w = '{UOP_YEAR,  DSEL_DAY,  DST_DAYS,   UA_MONTH};
            UA_MONTH:  w = '{UOP_MONTH, DSEL_DAY,  DST_DAYS,   UA_PACK};
            UA_PACK:   w = '{UOP_PACK,  DSEL_DAY,  DST_DAYS,   UA_WAIT};
            default:   w = '{UOP_PACK,  DSEL_DAY,  DST_DAYS,   UA_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/unix_seconds_to_dos_datetime.sv
// Unix seconds to broken-down UTC date/time plus FAT/DOS date and time words.
//
// Input channel: i_valid / o_stall carry one 32-bit seconds count. A
// transaction completes when i_valid is high and o_stall is low. o_stall is
// low only while the sequencer sits in its wait step, so one item is in work
// at a time.
// Output channel: o_valid / i_stall carry one result per input. The result
// sits in an output register, so the next input is taken while it waits.
//
// Steps from accept to o_valid: the all-ones "no time" input goes straight
// to the pack step. Otherwise each division by 86400, 3600, 60 and 7 takes
// two steps (reciprocal multiply for the quotient, multiply-subtract for the
// remainder), with one load step before the division by 7 and one after it,
// then one year and one month per cycle, then the pack step.
// A new input is taken only once the pack step has returned to the wait step.
//
// Reset (synchronous, active low) returns the sequencer to its wait step and
// drops o_valid. While i_stall holds a result, the block finishes the next
// item and holds it in the final step until the output register frees up.
module unix_seconds_to_dos_datetime (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_unix_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_index,
    output logic [7:0]  o_years_since_1900,
    output logic [2:0]  o_weekday,
    output logic [8:0]  o_day_of_year,
    output logic [15:0] o_fat_date,
    output logic [15:0] o_fat_time,
    output logic        o_invalid,
    output logic        o_before_1980
);
    import usdd_pkg::*;

    // sequencer
    t_upc       r_upc, n_upc;
    t_uword     uw;

    // working datapath
    logic [31:0] r_num, n_num;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_days, n_days;
    logic [4:0]  r_hr, n_hr;
    logic [5:0]  r_mn, n_mn;
    logic [5:0]  r_sc, n_sc;
    logic [2:0]  r_wd, n_wd;
    logic [7:0]  r_yr, n_yr;
    logic [8:0]  r_yd, n_yd;
    logic [3:0]  r_mo, n_mo;
    logic        r_inv, n_inv;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [5:0]  r_second, n_second;
    logic [5:0]  r_minute, n_minute;
    logic [4:0]  r_hour, n_hour;
    logic [4:0]  r_mday, n_mday;
    logic [3:0]  r_month, n_month;
    logic [7:0]  r_year, n_year;
    logic [2:0]  r_weekday, n_weekday;
    logic [8:0]  r_yday, n_yday;
    logic [15:0] r_fat_date, n_fat_date;
    logic [15:0] r_fat_time, n_fat_time;
    logic        r_invalid, n_invalid;
    logic        r_b1980, n_b1980;

    // reciprocal quotient and remainder, year/month lengths and packing helpers
    logic [24:0] mul_a;
    logic [25:0] mul_b;
    logic [50:0] prod;
    logic [15:0] quo;
    logic [31:0] qd;
    logic [31:0] rem;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [4:0]  mday;
    logic [6:0]  dos_yr;

    assign uw     = ucode(r_upc);
    assign mul_a  = pre_scale(uw.dsel, r_num);
    assign mul_b  = recip(uw.dsel);
    assign prod   = {26'd0, mul_a} * {25'd0, mul_b};
    assign quo    = quo_pick(uw.dsel, prod);
    assign qd     = {16'd0, r_quo} * {15'd0, divisor(uw.dsel)};
    assign rem    = r_num - qd;
    assign leap   = is_leap(r_yr);
    assign ylen   = leap ? 9'd366 : 9'd365;
    assign mlen   = month_len(r_mo, leap);
    assign mday   = r_num[4:0] + 5'd1;
    assign dos_yr = 7'(r_yr - DOS_YEAR);

    always_comb begin
        n_upc       = r_upc;
        n_num       = r_num;
        n_quo       = r_quo;
        n_days      = r_days;
        n_hr        = r_hr;
        n_mn        = r_mn;
        n_sc        = r_sc;
        n_wd        = r_wd;
        n_yr        = r_yr;
        n_yd        = r_yd;
        n_mo        = r_mo;
        n_inv       = r_inv;
        n_out_valid = r_out_valid && i_stall;
        n_second    = r_second;
        n_minute    = r_minute;
        n_hour      = r_hour;
        n_mday      = r_mday;
        n_month     = r_month;
        n_year      = r_year;
        n_weekday   = r_weekday;
        n_yday      = r_yday;
        n_fat_date  = r_fat_date;
        n_fat_time  = r_fat_time;
        n_invalid   = r_invalid;
        n_b1980     = r_b1980;

        case (uw.op)
            UOP_WAIT: begin
                if (i_valid) begin
                    n_num = i_unix_seconds;
                    n_inv = (i_unix_seconds == NO_TIME);
                    n_upc = (i_unix_seconds == NO_TIME) ? uw.target : r_upc + 4'd1;
                end
            end
            UOP_QUO: begin
                n_quo = quo;
                n_upc = r_upc + 4'd1;
            end
            UOP_REM: begin
                n_num = rem;
                n_upc = r_upc + 4'd1;
                case (uw.dst)
                    DST_DAYS: n_days = r_quo;
                    DST_HOUR: n_hr   = r_quo[4:0];
                    DST_MINSEC: begin
                        n_mn = r_quo[5:0];
                        n_sc = rem[5:0];
                    end
                    DST_WDAY: n_wd = rem[2:0];
                    default:  n_days = r_quo;
                endcase
            end
            UOP_LDW: begin
                n_num = {16'd0, r_days} + WDAY_OFFSET;
                n_upc = r_upc + 4'd1;
            end
            UOP_LDD: begin
                n_num = {16'd0, r_days};
                n_yr  = BASE_YEAR;
                n_mo  = '0;
                n_upc = r_upc + 4'd1;
            end
            UOP_YEAR: begin
                // one calendar year per cycle
                if ({23'd0, ylen} > r_num) begin
                    n_yd  = r_num[8:0];
                    n_upc = r_upc + 4'd1;
                end else begin
                    n_num = r_num - {23'd0, ylen};
                    n_yr  = r_yr + 8'd1;
                end
            end
            UOP_MONTH: begin
                if (({27'd0, mlen} > r_num) || (r_mo >= LAST_MONTH)) begin
                    n_upc = r_upc + 4'd1;
                end else begin
                    n_num = r_num - {27'd0, mlen};
                    n_mo  = r_mo + 4'd1;
                end
            end
            UOP_PACK: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_invalid   = r_inv;
                    n_second    = r_inv ? '0 : r_sc;
                    n_minute    = r_inv ? '0 : r_mn;
                    n_hour      = r_inv ? '0 : r_hr;
                    n_mday      = r_inv ? '0 : mday;
                    n_month     = r_inv ? '0 : r_mo;
                    n_year      = r_inv ? '0 : r_yr;
                    n_weekday   = r_inv ? '0 : r_wd;
                    n_yday      = r_inv ? '0 : r_yd;
                    n_fat_date  = r_inv ? '0 : {dos_yr, r_mo + 4'd1, mday};
                    n_fat_time  = r_inv ? '0 : {r_hr, r_mn, r_sc[5:1]};
                    n_b1980     = !r_inv && (r_yr < DOS_YEAR);
                    n_upc       = uw.target;
                end
            end
            default: n_upc = UA_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= UA_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_quo      <= n_quo;
        r_days     <= n_days;
        r_hr       <= n_hr;
        r_mn       <= n_mn;
        r_sc       <= n_sc;
        r_wd       <= n_wd;
        r_yr       <= n_yr;
        r_yd       <= n_yd;
        r_mo       <= n_mo;
        r_inv      <= n_inv;
        r_second   <= n_second;
        r_minute   <= n_minute;
        r_hour     <= n_hour;
        r_mday     <= n_mday;
        r_month    <= n_month;
        r_year     <= n_year;
        r_weekday  <= n_weekday;
        r_yday     <= n_yday;
        r_fat_date <= n_fat_date;
        r_fat_time <= n_fat_time;
        r_invalid  <= n_invalid;
        r_b1980    <= n_b1980;
    end

    assign o_stall            = (uw.op != UOP_WAIT);
    assign o_valid            = r_out_valid;
    assign o_second           = r_second;
    assign o_minute           = r_minute;
    assign o_hour             = r_hour;
    assign o_day_of_month     = r_mday;
    assign o_month_index      = r_month;
    assign o_years_since_1900 = r_year;
    assign o_weekday          = r_weekday;
    assign o_day_of_year      = r_yday;
    assign o_fat_date         = r_fat_date;
    assign o_fat_time         = r_fat_time;
    assign o_invalid          = r_invalid;
    assign o_before_1980      = r_b1980;

endmodule

FILE: sv/usdd_checker.sv
module usdd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [5:0]  o_second,
    input logic [5:0]  o_minute,
    input logic [4:0]  o_hour,
    input logic [4:0]  o_day_of_month,
    input logic [3:0]  o_month_index,
    input logic [7:0]  o_years_since_1900,
    input logic [15:0] o_fat_date,
    input logic [15:0] o_fat_time,
    input logic        o_invalid,
    input logic        o_before_1980
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_fat_date) && $stable(o_fat_time)
            && $stable(o_invalid))
        else $error("result changed under stall");

    // one transaction in work: busy right after an input is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while busy");

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_fat_date == 16'd0 && o_fat_time == 16'd0
            && o_years_since_1900 == 8'd0 && o_day_of_month == 5'd0 && !o_before_1980)
        else $error("invalid result carries nonzero fields");

    a_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid |-> o_fat_time == {o_hour, o_minute, o_second[5:1]}
            && o_fat_date[4:0] == o_day_of_month
            && o_fat_date[8:5] == o_month_index + 4'd1)
        else $error("packed words disagree with fields");

    a_b1980: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid |-> o_before_1980 == (o_years_since_1900 < 8'd80))
        else $error("before_1980 flag wrong");

endmodule

bind unix_seconds_to_dos_datetime usdd_checker u_usdd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_second           (o_second),
    .o_minute           (o_minute),
    .o_hour             (o_hour),
    .o_day_of_month     (o_day_of_month),
    .o_month_index      (o_month_index),
    .o_years_since_1900 (o_years_since_1900),
    .o_fat_date         (o_fat_date),
    .o_fat_time         (o_fat_time),
    .o_invalid          (o_invalid),
    .o_before_1980      (o_before_1980)
);
